// ===== sv/mat3_inverse_defines.svh =====
// assertion helpers shared by the mat3_inverse rtl
`ifndef MAT3_INVERSE_DEFINES_SVH
`define MAT3_INVERSE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MI3_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mat3_inverse: check failed");
`define MI3_ASSERT_IMPL(label, ante, cons) \
    `MI3_ASSERT(label, (ante) |-> (cons))
`else
`define MI3_ASSERT(label, prop)
`define MI3_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ===== sv/mi3_pkg.sv =====
package mi3_pkg;

    localparam int unsigned N_ELEM     = 9;
    localparam int unsigned N_ROW      = 3;
    localparam int unsigned ELEM_W     = 16;
    localparam int unsigned PROD_W     = 2 * ELEM_W;
    localparam int unsigned ADJ_W      = PROD_W + 1;
    localparam int unsigned TERM_W     = ELEM_W + ADJ_W;
    localparam int unsigned DET_W      = TERM_W;
    localparam int unsigned DMAG_W     = DET_W - 1;
    localparam int unsigned AMAG_W     = ADJ_W - 1;
    localparam int unsigned FRAC_SHIFT = 28;
    localparam int unsigned NUM_W      = AMAG_W + FRAC_SHIFT;
    localparam int unsigned QUO_W      = 32;
    localparam int unsigned OUT_W      = 32;
    localparam int unsigned PASS_SHIFT = 4;
    localparam int unsigned EXT_W      = OUT_W - ELEM_W - PASS_SHIFT;

    // pipeline depths in register stages
    localparam int unsigned COF_LAT   = 5;
    localparam int unsigned LANE_LAT  = QUO_W + 4;
    localparam int unsigned TOTAL_LAT = COF_LAT + LANE_LAT + 1;

    typedef logic [ELEM_W-1:0]        elem_t;
    typedef elem_t [N_ELEM-1:0]       mat_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ADJ_W-1:0]  adj_t;
    typedef adj_t [N_ELEM-1:0]        adj_mat_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [TERM_W+1:0] dsum_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [DMAG_W-1:0]        dmag_t;
    typedef logic [AMAG_W-1:0]        amag_t;
    typedef logic [NUM_W-1:0]         num_t;
    typedef logic [QUO_W-1:0]         quo_t;
    typedef logic [OUT_W-1:0]         out_t;
    typedef out_t [N_ELEM-1:0]        res_mat_t;

    typedef struct packed {
        dmag_t det_mag;
        logic  det_neg;
        logic  det_zero;
    } det_info_t;

    localparam out_t SAT_POS = 32'h7FFF_FFFF;
    localparam out_t SAT_NEG = 32'h8000_0000;

    // adjugate entry k = m[PA]*m[PB] - m[NA]*m[NB], transpose and sign folded in
    localparam int unsigned ADJ_PA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned ADJ_PB [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned ADJ_NA [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned ADJ_NB [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

// ===== sv/mi3_cofactor.sv =====
module mi3_cofactor (
    input  logic                clk,
    input  mi3_pkg::mat_t       m,
    output mi3_pkg::adj_mat_t   adj,
    output mi3_pkg::det_info_t  det_info
);

    mi3_pkg::prod_t    prod_p_reg [mi3_pkg::N_ELEM];
    mi3_pkg::prod_t    prod_p_next [mi3_pkg::N_ELEM];
    mi3_pkg::prod_t    prod_n_reg [mi3_pkg::N_ELEM];
    mi3_pkg::prod_t    prod_n_next [mi3_pkg::N_ELEM];
    mi3_pkg::elem_t    row0_a_reg [mi3_pkg::N_ROW];
    mi3_pkg::elem_t    row0_b_reg [mi3_pkg::N_ROW];
    mi3_pkg::adj_mat_t adj_b_reg;
    mi3_pkg::adj_mat_t adj_b_next;
    mi3_pkg::adj_mat_t adj_c_reg;
    mi3_pkg::adj_mat_t adj_d_reg;
    mi3_pkg::adj_mat_t adj_e_reg;
    mi3_pkg::term_t    term_reg [mi3_pkg::N_ROW];
    mi3_pkg::term_t    term_next [mi3_pkg::N_ROW];
    mi3_pkg::dsum_t    det_sum;
    mi3_pkg::det_t     det_reg;
    mi3_pkg::det_t     det_next;
    mi3_pkg::det_t     det_abs;
    mi3_pkg::det_info_t info_reg;
    mi3_pkg::det_info_t info_next;

    genvar k;
    generate
        for (k = 0; k < mi3_pkg::N_ELEM; k++)
        begin : g_adj
            assign prod_p_next[k] = $signed(m[mi3_pkg::ADJ_PA[k]])
                                  * $signed(m[mi3_pkg::ADJ_PB[k]]);
            assign prod_n_next[k] = $signed(m[mi3_pkg::ADJ_NA[k]])
                                  * $signed(m[mi3_pkg::ADJ_NB[k]]);
            assign adj_b_next[k]  = mi3_pkg::adj_t'(prod_p_reg[k])
                                  - mi3_pkg::adj_t'(prod_n_reg[k]);
        end
        for (k = 0; k < mi3_pkg::N_ROW; k++)
        begin : g_term
            // expansion along row 0 pairs m[0][c] with adjugate entry [c][0]
            assign term_next[k] = $signed(row0_b_reg[k])
                                * $signed(adj_b_reg[k * mi3_pkg::N_ROW]);
        end
    endgenerate

    always_comb
    begin
        det_sum  = mi3_pkg::dsum_t'(term_reg[0]) + mi3_pkg::dsum_t'(term_reg[1])
                 + mi3_pkg::dsum_t'(term_reg[2]);
        det_next = det_sum[mi3_pkg::DET_W-1:0];
        det_abs  = det_reg[mi3_pkg::DET_W-1] ? -det_reg : det_reg;
        info_next.det_mag  = det_abs[mi3_pkg::DMAG_W-1:0];
        info_next.det_neg  = det_reg[mi3_pkg::DET_W-1];
        info_next.det_zero = (det_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        prod_p_reg <= prod_p_next;
        prod_n_reg <= prod_n_next;
        row0_a_reg <= '{m[0], m[1], m[2]};
        adj_b_reg  <= adj_b_next;
        row0_b_reg <= row0_a_reg;
        term_reg   <= term_next;
        adj_c_reg  <= adj_b_reg;
        det_reg    <= det_next;
        adj_d_reg  <= adj_c_reg;
        info_reg   <= info_next;
        adj_e_reg  <= adj_d_reg;
    end

    assign adj      = adj_e_reg;
    assign det_info = info_reg;

endmodule

// ===== sv/mi3_div_lane.sv =====
module mi3_div_lane (
    input  logic               clk,
    input  mi3_pkg::adj_t      adj,
    input  mi3_pkg::det_info_t det_info,
    output mi3_pkg::out_t      res
);

    localparam int unsigned STEPS = mi3_pkg::QUO_W;

    // front stages: magnitude, rounded numerator, overflow check
    mi3_pkg::adj_t  adj_abs;
    mi3_pkg::amag_t amag_reg;
    logic           neg1_reg;
    mi3_pkg::dmag_t d1_reg;
    mi3_pkg::num_t  num_reg;
    mi3_pkg::num_t  num_next;
    logic           neg2_reg;
    mi3_pkg::dmag_t d2_reg;

    // one restoring step per stage
    mi3_pkg::dmag_t rem_reg [STEPS+1];
    mi3_pkg::quo_t  low_reg [STEPS+1];
    mi3_pkg::quo_t  q_reg   [STEPS+1];
    mi3_pkg::dmag_t d_reg   [STEPS+1];
    logic           neg_reg [STEPS+1];
    logic           ovf_reg [STEPS+1];

    mi3_pkg::out_t  res_reg;
    mi3_pkg::out_t  res_next;
    mi3_pkg::quo_t  q_fin;

    assign adj_abs  = adj[mi3_pkg::ADJ_W-1] ? -adj : adj;
    // round half away from zero: add half the divisor before dividing
    assign num_next = {amag_reg, {mi3_pkg::FRAC_SHIFT{1'b0}}}
                    + mi3_pkg::num_t'(d1_reg[mi3_pkg::DMAG_W-1:1]);

    always_ff @(posedge clk)
    begin
        amag_reg   <= adj_abs[mi3_pkg::AMAG_W-1:0];
        neg1_reg   <= adj[mi3_pkg::ADJ_W-1] ^ det_info.det_neg;
        d1_reg     <= det_info.det_mag;
        num_reg    <= num_next;
        neg2_reg   <= neg1_reg;
        d2_reg     <= d1_reg;
        // quotient of 2^32 or more always saturates
        ovf_reg[0] <= mi3_pkg::dmag_t'(num_reg[mi3_pkg::NUM_W-1:STEPS]) >= d2_reg;
        rem_reg[0] <= mi3_pkg::dmag_t'(num_reg[mi3_pkg::NUM_W-1:STEPS]);
        low_reg[0] <= num_reg[STEPS-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= d2_reg;
        neg_reg[0] <= neg2_reg;
    end

    genvar s;
    generate
        for (s = 0; s < STEPS; s++)
        begin : g_step
            logic [mi3_pkg::DMAG_W:0] trial;
            logic [mi3_pkg::DMAG_W:0] diff;
            logic                     ge;
            mi3_pkg::dmag_t           rem_next;

            assign trial    = {rem_reg[s], low_reg[s][STEPS-1]};
            assign diff     = trial - {1'b0, d_reg[s]};
            assign ge       = trial >= {1'b0, d_reg[s]};
            assign rem_next = ge ? diff[mi3_pkg::DMAG_W-1:0]
                                 : trial[mi3_pkg::DMAG_W-1:0];

            always_ff @(posedge clk)
            begin
                rem_reg[s+1] <= rem_next;
                low_reg[s+1] <= {low_reg[s][STEPS-2:0], 1'b0};
                q_reg[s+1]   <= {q_reg[s][STEPS-2:0], ge};
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    endgenerate

    assign q_fin = q_reg[STEPS];

    always_comb
    begin
        if (neg_reg[STEPS])
        begin
            if (ovf_reg[STEPS] || q_fin > mi3_pkg::quo_t'(mi3_pkg::SAT_NEG))
                res_next = mi3_pkg::SAT_NEG;
            else
                res_next = mi3_pkg::out_t'(-q_fin);
        end
        else
        begin
            if (ovf_reg[STEPS] || q_fin > mi3_pkg::quo_t'(mi3_pkg::SAT_POS))
                res_next = mi3_pkg::SAT_POS;
            else
                res_next = mi3_pkg::out_t'(q_fin);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== sv/mi3_merge.sv =====
module mi3_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld,
    input  logic              sing,
    input  mi3_pkg::mat_t     elem,
    input  mi3_pkg::res_mat_t lane_res,
    output logic              done,
    output logic              singular,
    output mi3_pkg::res_mat_t res
);

    logic              done_reg;
    logic              sing_reg;
    mi3_pkg::res_mat_t res_reg;
    mi3_pkg::res_mat_t res_next;

    // a zero determinant passes the input through, Q4.12 widened to Q16.16
    always_comb
    begin
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
        begin
            if (sing)
                res_next[k] = {{mi3_pkg::EXT_W{elem[k][mi3_pkg::ELEM_W-1]}}, elem[k],
                               {mi3_pkg::PASS_SHIFT{1'b0}}};
            else
                res_next[k] = lane_res[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld;
    end

    always_ff @(posedge clk)
    begin
        sing_reg <= sing;
        res_reg  <= res_next;
    end

    assign done     = done_reg;
    assign singular = sing_reg;
    assign res      = res_reg;

endmodule

// ===== sv/mat3_inverse.sv =====
// 3x3 matrix inverse by the adjugate method, signed Q4.12 in, Q16.16 out.
// input transaction: the nine elements, row by row, are taken at a rising
// edge with start high and busy low. busy is never raised, so a new matrix
// may be started in every cycle.
// output transaction: done is high for exactly one cycle together with the
// nine inverse elements and the singular flag; the receiver cannot stall,
// so it must take each result in the cycle it is shown.
// from the accepting edge to the edge that takes the result, a matrix passes
// 5 stages of products, adjugate and determinant, 36 stages in each of the
// nine divider lanes (32 of them one quotient bit each), and one merge
// stage. throughput is one matrix per cycle, set by the nine fully
// pipelined divider lanes.
// singular matrices (determinant exactly zero) come back unchanged, scaled
// to Q16.16, with singular high. other results are rounded and saturated.
// reset clears the transaction tracking only; items in flight are dropped
// and no done pulse appears until a matrix is started after reset.
`include "mat3_inverse_defines.svh"

module mat3_inverse (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] in_r0_c0,
    input  logic [15:0] in_r0_c1,
    input  logic [15:0] in_r0_c2,
    input  logic [15:0] in_r1_c0,
    input  logic [15:0] in_r1_c1,
    input  logic [15:0] in_r1_c2,
    input  logic [15:0] in_r2_c0,
    input  logic [15:0] in_r2_c1,
    input  logic [15:0] in_r2_c2,
    output logic        done,
    output logic [31:0] out_r0_c0,
    output logic [31:0] out_r0_c1,
    output logic [31:0] out_r0_c2,
    output logic [31:0] out_r1_c0,
    output logic [31:0] out_r1_c1,
    output logic [31:0] out_r1_c2,
    output logic [31:0] out_r2_c0,
    output logic [31:0] out_r2_c1,
    output logic [31:0] out_r2_c2,
    output logic        singular
);

    localparam int unsigned FLIGHT = mi3_pkg::COF_LAT + mi3_pkg::LANE_LAT;

    mi3_pkg::mat_t      m_in;
    mi3_pkg::adj_mat_t  adj;
    mi3_pkg::det_info_t det_info;
    mi3_pkg::res_mat_t  lane_res;
    mi3_pkg::res_mat_t  res;

    logic [FLIGHT-1:0]            vld_reg;
    logic [mi3_pkg::LANE_LAT-1:0] sing_reg;
    mi3_pkg::mat_t                elem_reg [FLIGHT];

    assign busy = 1'b0;

    assign m_in = {in_r2_c2, in_r2_c1, in_r2_c0,
                   in_r1_c2, in_r1_c1, in_r1_c0,
                   in_r0_c2, in_r0_c1, in_r0_c0};

    mi3_cofactor u_cofactor (
        .clk      (clk),
        .m        (m_in),
        .adj      (adj),
        .det_info (det_info)
    );

    genvar k;
    generate
        for (k = 0; k < mi3_pkg::N_ELEM; k++)
        begin : g_lane
            mi3_div_lane u_lane (
                .clk      (clk),
                .adj      (adj[k]),
                .det_info (det_info),
                .res      (lane_res[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[FLIGHT-2:0], start & ~busy};
    end

    // input copy and singular flag ride alongside the lanes for the bypass
    always_ff @(posedge clk)
    begin
        elem_reg[0] <= m_in;
        for (int i = 1; i < FLIGHT; i++)
            elem_reg[i] <= elem_reg[i-1];
        sing_reg <= {sing_reg[mi3_pkg::LANE_LAT-2:0], det_info.det_zero};
    end

    mi3_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld      (vld_reg[FLIGHT-1]),
        .sing     (sing_reg[mi3_pkg::LANE_LAT-1]),
        .elem     (elem_reg[FLIGHT-1]),
        .lane_res (lane_res),
        .done     (done),
        .singular (singular),
        .res      (res)
    );

    assign out_r0_c0 = res[0];
    assign out_r0_c1 = res[1];
    assign out_r0_c2 = res[2];
    assign out_r1_c0 = res[3];
    assign out_r1_c1 = res[4];
    assign out_r1_c2 = res[5];
    assign out_r2_c0 = res[6];
    assign out_r2_c1 = res[7];
    assign out_r2_c2 = res[8];

    `MI3_ASSERT(a_start_gives_done, start && !busy |-> ##(mi3_pkg::TOTAL_LAT) done)
    `MI3_ASSERT_IMPL(a_done_has_start, done, $past(start, mi3_pkg::TOTAL_LAT))
    `MI3_ASSERT_IMPL(a_bypass_scaled, done && singular,
        out_r0_c0[3:0] == 4'd0 && out_r1_c1[3:0] == 4'd0 && out_r2_c2[3:0] == 4'd0)

endmodule

// ===== verif/tb_mat3_inverse.sv =====
module tb_mat3_inverse;

    typedef struct packed {
        mi3_pkg::res_mat_t el;
        logic              sing;
    } inv_result_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          done;
    logic          singular;
    mi3_pkg::mat_t in_m;
    wire [mi3_pkg::N_ELEM-1:0][mi3_pkg::OUT_W-1:0] out_m;

    mi3_pkg::mat_t matrix_q[$];
    inv_result_t   inverse_q[$];
    int            taken_cnt;
    int            err_cnt;

    mat3_inverse u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_r0_c0  (in_m[0]),
        .in_r0_c1  (in_m[1]),
        .in_r0_c2  (in_m[2]),
        .in_r1_c0  (in_m[3]),
        .in_r1_c1  (in_m[4]),
        .in_r1_c2  (in_m[5]),
        .in_r2_c0  (in_m[6]),
        .in_r2_c1  (in_m[7]),
        .in_r2_c2  (in_m[8]),
        .done      (done),
        .out_r0_c0 (out_m[0]),
        .out_r0_c1 (out_m[1]),
        .out_r0_c2 (out_m[2]),
        .out_r1_c0 (out_m[3]),
        .out_r1_c1 (out_m[4]),
        .out_r1_c2 (out_m[5]),
        .out_r2_c0 (out_m[6]),
        .out_r2_c1 (out_m[7]),
        .out_r2_c2 (out_m[8]),
        .singular  (singular)
    );

    // adjugate entry times 2^28 over the determinant, rounded half away, saturated
    function automatic mi3_pkg::out_t scaled_quotient(input longint num, input longint den);
        bit                neg;
        longint unsigned   n;
        longint unsigned   d;
        longint unsigned   q;
        neg = (num < 0) != (den < 0);
        n = longint'(num < 0 ? -num : num);
        n = n << mi3_pkg::FRAC_SHIFT;
        d = longint'(den < 0 ? -den : den);
        q = (n + d / 2) / d;
        if (num == 0)
            return '0;
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return mi3_pkg::out_t'(-q);
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return mi3_pkg::out_t'(q);
    endfunction

    function automatic inv_result_t inverse_of(input mi3_pkg::mat_t m);
        longint      e[9];
        longint      a[9];
        longint      det;
        inv_result_t res;
        for (int k = 0; k < 9; k++)
            e[k] = $signed(m[k]);
        // transposed cofactors, row by row
        a[0] =   e[4] * e[8] - e[5] * e[7];
        a[1] = -(e[1] * e[8] - e[2] * e[7]);
        a[2] =   e[1] * e[5] - e[2] * e[4];
        a[3] = -(e[3] * e[8] - e[5] * e[6]);
        a[4] =   e[0] * e[8] - e[2] * e[6];
        a[5] = -(e[0] * e[5] - e[2] * e[3]);
        a[6] =   e[3] * e[7] - e[4] * e[6];
        a[7] = -(e[0] * e[7] - e[1] * e[6]);
        a[8] =   e[0] * e[4] - e[1] * e[3];
        det = e[0] * a[0] + e[1] * a[3] + e[2] * a[6];
        res.sing = (det == 0);
        for (int k = 0; k < 9; k++)
        begin
            if (det == 0)
                res.el[k] = mi3_pkg::out_t'(e[k] * 16);
            else
                res.el[k] = scaled_quotient(a[k], det);
        end
        return res;
    endfunction

    function automatic mi3_pkg::mat_t rows(input int a, input int b, input int c,
                                           input int d, input int e, input int f,
                                           input int g, input int h, input int i);
        mi3_pkg::mat_t m;
        m[0] = mi3_pkg::elem_t'(a);
        m[1] = mi3_pkg::elem_t'(b);
        m[2] = mi3_pkg::elem_t'(c);
        m[3] = mi3_pkg::elem_t'(d);
        m[4] = mi3_pkg::elem_t'(e);
        m[5] = mi3_pkg::elem_t'(f);
        m[6] = mi3_pkg::elem_t'(g);
        m[7] = mi3_pkg::elem_t'(h);
        m[8] = mi3_pkg::elem_t'(i);
        return m;
    endfunction

    function automatic mi3_pkg::elem_t corner_elem();
        case ($urandom_range(5))
            0: return mi3_pkg::elem_t'(32767);
            1: return mi3_pkg::elem_t'(-32768);
            2: return mi3_pkg::elem_t'(0);
            3: return mi3_pkg::elem_t'(1);
            4: return mi3_pkg::elem_t'(-1);
            default: return mi3_pkg::elem_t'(4096);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input mi3_pkg::out_t got,
                                   input mi3_pkg::out_t want);
        err_cnt++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus: directed matrices first, then random ones
    initial
    begin
        mi3_pkg::mat_t m;
        int            kind;
        int            src;
        matrix_q.push_back(rows(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
        matrix_q.push_back(rows(0, 0, 0, 0, 0, 0, 0, 0, 0));
        matrix_q.push_back(rows(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767));
        matrix_q.push_back(rows(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768));
        matrix_q.push_back(rows(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        matrix_q.push_back(rows(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        matrix_q.push_back(rows(1, 0, 0, 0, 1, 0, 0, 0, 1));
        matrix_q.push_back(rows(-1, 0, 0, 0, -1, 0, 0, 0, -1));
        matrix_q.push_back(rows(1, 0, 0, 0, 1, 0, 0, 0, 3));
        // inverse entry of exactly +2^31 saturates, exactly -2^31 does not
        matrix_q.push_back(rows(1, 7, 0, 1, 8, 0, 0, 0, 1));
        matrix_q.push_back(rows(1, 9, 0, 1, 8, 0, 0, 0, 1));
        // nearly singular, both saturation signs
        matrix_q.push_back(rows(32767, 32766, 0, 32766, 32765, 0, 0, 0, 4096));
        matrix_q.push_back(rows(-32768, 32767, 1, 32767, -32768, -1, 0, 1, -32768));
        matrix_q.push_back(rows(0, 4096, 0, 0, 0, 4096, 4096, 0, 0));
        matrix_q.push_back(rows(32767, -32768, 1, 32767, -32768, 1, -1, 0, 5));
        matrix_q.push_back(rows(-32768, 32767, -1, 1, -32768, 32767, 32767, -1, -32768));
        matrix_q.push_back(rows(2048, -4096, 8192, 0, 16384, -12288, 4096, 4096, -2048));
        matrix_q.push_back(rows(-32768, 0, 32767, 0, 1, 0, 32767, 0, -32768));
        for (int n = 0; n < 1000; n++)
        begin
            kind = $urandom_range(99);
            for (int k = 0; k < 9; k++)
                m[k] = mi3_pkg::elem_t'($urandom);
            if (kind < 15)
            begin
                // singular: a copied row, a copied column or a zero row
                src = $urandom_range(2);
                case ($urandom_range(2))
                    0: for (int c = 0; c < 3; c++) m[((src + 1) % 3) * 3 + c] = m[src * 3 + c];
                    1: for (int r = 0; r < 3; r++) m[r * 3 + (src + 2) % 3] = m[r * 3 + src];
                    default: for (int c = 0; c < 3; c++) m[src * 3 + c] = '0;
                endcase
            end
            else if (kind < 30)
            begin
                for (int k = 0; k < 9; k++)
                    m[k] = mi3_pkg::elem_t'($urandom_range(64) - 32);
            end
            else if (kind < 42)
            begin
                // one row close to another, small determinant
                for (int c = 0; c < 3; c++)
                    m[6 + c] = m[c] + mi3_pkg::elem_t'($urandom_range(4) - 2);
            end
            else if (kind < 50)
            begin
                for (int k = 0; k < 9; k++)
                    m[k] = corner_elem();
            end
            matrix_q.push_back(m);
        end
    end

    // driver
    always @(negedge clk)
    begin
        bit rest;
        rest = !(taken_cnt >= 400 && taken_cnt < 650) && ($urandom_range(99) < 37);
        if (rst_n && matrix_q.size() != 0 && !rest)
        begin
            start <= 1'b1;
            in_m  <= matrix_q[0];
        end
        else
        begin
            start <= 1'b0;
            in_m  <= {mi3_pkg::N_ELEM{mi3_pkg::elem_t'($urandom)}};
        end
    end

    initial
    begin
        start     = 1'b0;
        in_m      = '0;
        taken_cnt = 0;
        err_cnt   = 0;
    end

    // monitor and transaction tracking
    always @(posedge clk)
    begin
        inv_result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (inverse_q.size() == 0)
                    report_mismatch("result with no matrix pending", out_m[0], '0);
                else
                begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (out_m[k] !== want.el[k])
                            report_mismatch($sformatf("out_r%0d_c%0d", k / 3, k % 3),
                                            out_m[k], want.el[k]);
                    if (singular !== want.sing)
                        report_mismatch("singular", mi3_pkg::out_t'(singular),
                                        mi3_pkg::out_t'(want.sing));
                end
            end
            if (start && busy === 1'b0)
            begin
                inverse_q.push_back(inverse_of(in_m));
                void'(matrix_q.pop_front());
                taken_cnt++;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (matrix_q.size() != 0 || inverse_q.size() != 0)
            @(posedge clk);
        repeat (mi3_pkg::TOTAL_LAT + 8) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== mat3_inverse.f =====
+incdir+sv
sv/mi3_pkg.sv
sv/mi3_cofactor.sv
sv/mi3_div_lane.sv
sv/mi3_merge.sv
sv/mat3_inverse.sv
verif/tb_mat3_inverse.sv
